// File: design/sssat_pkg.sv
// ----------------------------------------------------------------------------
// sssat_pkg
// Shared constants, types and the sine table of the slew saturator.
// ----------------------------------------------------------------------------
package sssat_pkg;

	localparam int MAX_STAGES  = 128;
	localparam int SAMPLE_BITS = 24;
	localparam int STAGE_W     = $clog2(MAX_STAGES);
	localparam int NST_W       = $clog2(MAX_STAGES + 1);
	localparam int ADDR_W      = STAGE_W + 1;
	localparam int RAM_DEPTH   = 2 ** ADDR_W;
	localparam int STORE_W     = 32;
	localparam int DIFF_W      = STORE_W + 1;
	localparam int SUM_W       = STORE_W + 2;
	localparam int X0_SHIFT    = 29 - SAMPLE_BITS;
	localparam int OUT_SHIFT   = 45 - SAMPLE_BITS;
	localparam int MUL_W       = 34;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = 52;
	localparam int FRAC_W      = 22;
	localparam int ROM_STEPS   = 256;
	localparam int ROM_IDX_W   = $clog2(ROM_STEPS + 1);
	localparam int ROM_W       = 32;

	localparam logic [63:0]             HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [MUL_W-1:0] PHASE_K     = 34'sd2734261102;

	typedef logic [ROM_STEPS:0][ROM_W-1:0] rom_t;

	// sin(k*pi/512) in Q1.30 from a truncated Taylor series, built at elaboration.
	function automatic rom_t build_sin_rom();
		rom_t                r;
		logic [63:0]         x;
		logic [63:0]         t;
		logic signed [63:0]  acc;
		for (int k = 0; k <= ROM_STEPS; k++) begin
			x   = (64'(k) * HALF_PI_Q30 + 64'(ROM_STEPS / 2)) / 64'(ROM_STEPS);
			t   = x;
			acc = $signed(x);
			for (int n = 1; n <= 8; n++) begin
				t = (((t * x) >> 30) * x) >> 30;
				t = t / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - $signed(t);
				end else begin
					acc = acc + $signed(t);
				end
			end
			r[k] = acc[ROM_W-1:0];
		end
		return r;
	endfunction

	localparam rom_t SIN_ROM = build_sin_rom();

	typedef enum logic [1:0] {
		CFG_SOURCE_GAIN = 2'd0,
		CFG_STAGE_COUNT = 2'd1,
		CFG_WET_GAIN    = 2'd2,
		CFG_DRY_GAIN    = 2'd3
	} cfg_reg_e_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DIFF,
		ST_PHASE,
		ST_TABLE,
		ST_INTERP,
		ST_SUM,
		ST_GAIN,
		ST_WRITE,
		ST_MIXW,
		ST_MIXD,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_PHASE,
		MUL_INTERP,
		MUL_GAIN,
		MUL_WET,
		MUL_DRY
	} mul_sel_t;

	typedef struct packed {
		state_t              state;
		logic                ch;
		logic [STAGE_W-1:0]  stage;
		logic                in_ready;
		logic                ram_re;
		logic [ADDR_W-1:0]   ram_raddr;
		logic                ram_we;
		logic                mul_en;
		mul_sel_t            mul_sel;
	} ctrl_t;

endpackage

// File: design/sssat_ram.sv
// ----------------------------------------------------------------------------
// sssat_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sssat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/sssat_mul.sv
// ----------------------------------------------------------------------------
// sssat_mul
// The shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sssat_mul import sssat_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

	assign prod = prod_q;

endmodule

// File: design/sssat_seq.sv
// ----------------------------------------------------------------------------
// sssat_seq
// Sequencer: walks both channels through the active stages and the mix.
// ----------------------------------------------------------------------------
module sssat_seq import sssat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_free,
	input  logic [NST_W-1:0] nstages,
	output ctrl_t            ctrl
);

	state_t             state_q;
	state_t             state_d;
	logic               ch_q;
	logic [STAGE_W-1:0] stage_q;
	logic               last_stage;

	assign last_stage = (stage_q == STAGE_W'(nstages - NST_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= 1'b0;
			stage_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				ch_q <= 1'b0;
			end else if (state_q == ST_OUT && !ch_q) begin
				ch_q <= 1'b1;
			end
			if (state_q == ST_START) begin
				stage_q <= '0;
			end else if (state_q == ST_WRITE && !last_stage) begin
				stage_q <= stage_q + STAGE_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_START;
			ST_START:  state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_PHASE;
			ST_PHASE:  state_d = ST_TABLE;
			ST_TABLE:  state_d = ST_INTERP;
			ST_INTERP: state_d = ST_SUM;
			ST_SUM:    state_d = ST_GAIN;
			ST_GAIN:   state_d = ST_WRITE;
			ST_WRITE:  state_d = last_stage ? ST_MIXW : ST_DIFF;
			ST_MIXW:   state_d = ST_MIXD;
			ST_MIXD:   state_d = ST_OUT;
			ST_OUT: begin
				if (!ch_q) begin
					state_d = ST_START;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.state     = state_q;
		ctrl.ch        = ch_q;
		ctrl.stage     = stage_q;
		ctrl.ram_raddr = {ch_q, stage_q};
		ctrl.mul_sel   = MUL_PHASE;
		unique case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_START: begin
				ctrl.ram_re    = 1'b1;
				ctrl.ram_raddr = {ch_q, STAGE_W'(0)};
			end
			ST_PHASE: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_PHASE;
			end
			ST_INTERP: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_INTERP;
			end
			ST_GAIN: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_GAIN;
			end
			ST_WRITE: begin
				// The next stage's store is fetched while this one is written back.
				ctrl.ram_we    = 1'b1;
				ctrl.ram_re    = !last_stage;
				ctrl.ram_raddr = {ch_q, stage_q + STAGE_W'(1)};
			end
			ST_MIXW: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_WET;
			end
			ST_MIXD: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_DRY;
			end
			ST_DIFF, ST_TABLE, ST_SUM, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/sine_slew_cascade_saturator_core.sv
// ----------------------------------------------------------------------------
// sine_slew_cascade_saturator_core
// Stereo saturator built from a cascade of sine shaped slew stages.
// ----------------------------------------------------------------------------
// No new stereo pair is accepted until both channels of the last one are
// through. The channels run one after the other through N stages each, N
// being the active stage count (1 to 128). Each stage takes seven steps
// around one read and one write of the slew store RAM, three of them on the
// single shared multiplier: the phase product, the table interpolation and
// the source gain. The mix of a channel takes the wet product, the dry
// product and an output step. Slew stores read as zero after reset through a
// valid bit per entry, so there is no clearing pass. A finished pair waits in
// the output register while the next pair is already accepted; configuration
// writes are taken at any time and must only be issued while the block is idle.
module sine_slew_cascade_saturator_core import sssat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // left_sample [23:0], right_sample [47:24]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // left_out [23:0], right_out [47:24]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	localparam logic signed [STORE_W-1:0] Y_MAX = {1'b0, {(STORE_W-1){1'b1}}};
	localparam logic signed [STORE_W-1:0] Y_MIN = {1'b1, {(STORE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] O_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] O_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [ACC_W:0] RND = (ACC_W+1)'(1) <<< (OUT_SHIFT - 1);

	// Configuration registers
	logic [16:0]        source_gain_q;
	logic [7:0]         stage_count_q;
	logic signed [17:0] wet_gain_q;
	logic [16:0]        dry_gain_q;
	logic [NST_W-1:0]   nstages;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_gain_q <= 17'd65536;
			stage_count_q <= 8'd1;
			wet_gain_q    <= 18'sd65536;
			dry_gain_q    <= 17'd0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_e_t'(cfg_index))
				CFG_SOURCE_GAIN: source_gain_q <= cfg_data[16:0];
				CFG_STAGE_COUNT: stage_count_q <= cfg_data[7:0];
				CFG_WET_GAIN:    wet_gain_q    <= $signed(cfg_data);
				CFG_DRY_GAIN:    dry_gain_q    <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (stage_count_q == '0) begin
			nstages = NST_W'(1);
		end else if (int'(stage_count_q) > MAX_STAGES) begin
			nstages = NST_W'(MAX_STAGES);
		end else begin
			nstages = NST_W'(stage_count_q);
		end
	end

	// Sequencer
	ctrl_t ctrl;
	logic  out_valid_q;
	logic  out_free;

	assign out_free = !out_valid_q || m_axis_tready;

	sssat_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.nstages  (nstages),
		.ctrl     (ctrl)
	);

	assign s_axis_tready = ctrl.in_ready;

	// Input samples
	logic signed [SAMPLE_BITS-1:0] left_in_q;
	logic signed [SAMPLE_BITS-1:0] right_in_q;
	logic signed [SAMPLE_BITS-1:0] samp;
	logic signed [STORE_W-1:0]     x0;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			left_in_q  <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
			right_in_q <= $signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
		end
	end

	assign samp = ctrl.ch ? right_in_q : left_in_q;
	assign x0   = STORE_W'(samp) <<< X0_SHIFT;

	// Slew store RAM, both channels, addressed by {channel, stage}
	logic                      ram_we;
	logic [ADDR_W-1:0]         wr_addr;
	logic [STORE_W-1:0]        ram_wdata;
	logic [STORE_W-1:0]        ram_rdata;
	logic [RAM_DEPTH-1:0]      valid_q;
	logic                      rd_valid_q;
	logic signed [STORE_W-1:0] s_val;

	assign ram_we  = ctrl.ram_we;
	assign wr_addr = {ctrl.ch, ctrl.stage};

	sssat_ram #(
		.WIDTH (STORE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (ram_wdata),
		.re    (ctrl.ram_re),
		.raddr (ctrl.ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctrl.ram_re) begin
				rd_valid_q <= valid_q[ctrl.ram_raddr];
			end
		end
	end

	assign s_val = rd_valid_q ? $signed(ram_rdata) : '0;

	// Shared multiplier
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;

	sssat_mul u_mul (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// Stage datapath
	logic signed [STORE_W-1:0] x_q;
	logic signed [STORE_W-1:0] s_q;
	logic signed [DIFF_W-1:0]  d_q;
	logic signed [ROM_W-1:0]   a_q;
	logic signed [ROM_W:0]     dab_q;
	logic [FRAC_W-1:0]         f_q;
	logic                      neg_q;
	logic signed [SUM_W-1:0]   sum_q;

	logic [31:0]               phase;
	logic [1:0]                quad;
	logic [7:0]                idx;
	logic [ROM_IDX_W-1:0]      a_idx;
	logic [ROM_IDX_W-1:0]      b_idx;
	logic signed [ROM_W-1:0]   rom_a;
	logic signed [ROM_W-1:0]   rom_b;

	logic signed [MUL_W-1:0]   interp;
	logic signed [MUL_W:0]     v;
	logic signed [MUL_W+1:0]   vn;
	logic signed [MUL_W+1:0]   half;
	logic signed [MUL_W+1:0]   sum_full;

	logic signed [PROD_W-17:0] gain_sh;
	logic signed [STORE_W-1:0] y;
	logic signed [DIFF_W-1:0]  yf;

	assign phase = prod[61:30];
	assign quad  = phase[31:30];
	assign idx   = phase[29:22];
	// Odd quadrants read the table backwards.
	assign a_idx = quad[0] ? ROM_IDX_W'(ROM_STEPS) - ROM_IDX_W'(idx) : ROM_IDX_W'(idx);
	assign b_idx = quad[0] ? ROM_IDX_W'(ROM_STEPS - 1) - ROM_IDX_W'(idx)
	                       : ROM_IDX_W'(idx) + ROM_IDX_W'(1);
	assign rom_a = $signed(SIN_ROM[a_idx]);
	assign rom_b = $signed(SIN_ROM[b_idx]);

	assign interp   = prod[FRAC_W+MUL_W-1:FRAC_W];
	assign v        = (MUL_W+1)'(a_q) + (MUL_W+1)'(interp);
	assign vn       = neg_q ? -((MUL_W+2)'(v)) : (MUL_W+2)'(v);
	assign half     = vn >>> 3;
	assign sum_full = (MUL_W+2)'(s_q) + half;

	assign gain_sh = prod[PROD_W-1:16];
	always_comb begin
		if (gain_sh > (PROD_W-16)'(Y_MAX)) begin
			y = Y_MAX;
		end else if (gain_sh < (PROD_W-16)'(Y_MIN)) begin
			y = Y_MIN;
		end else begin
			y = gain_sh[STORE_W-1:0];
		end
	end

	assign ram_wdata = y >>> 1;
	// An odd stage count flips the sign of the cascade output.
	assign yf = nstages[0] ? -(DIFF_W'(x_q)) : DIFF_W'(x_q);

	always_comb begin
		case (ctrl.mul_sel)
			MUL_PHASE: begin
				mul_a = MUL_W'(d_q);
				mul_b = PHASE_K;
			end
			MUL_INTERP: begin
				mul_a = MUL_W'(dab_q);
				mul_b = MUL_W'($signed({1'b0, f_q}));
			end
			MUL_GAIN: begin
				mul_a = MUL_W'(sum_q);
				mul_b = MUL_W'($signed({1'b0, source_gain_q}));
			end
			MUL_WET: begin
				mul_a = MUL_W'(yf);
				mul_b = MUL_W'(wet_gain_q);
			end
			MUL_DRY: begin
				mul_a = MUL_W'(x0);
				mul_b = MUL_W'($signed({1'b0, dry_gain_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.state == ST_START) begin
			x_q <= x0;
		end else if (ctrl.state == ST_WRITE) begin
			x_q <= y;
		end
		if (ctrl.state == ST_DIFF) begin
			s_q <= s_val;
			d_q <= DIFF_W'(s_val) - DIFF_W'(x_q);
		end
		if (ctrl.state == ST_TABLE) begin
			a_q   <= rom_a;
			dab_q <= (ROM_W+1)'(rom_b) - (ROM_W+1)'(rom_a);
			f_q   <= phase[FRAC_W-1:0];
			neg_q <= quad[1];
		end
		if (ctrl.state == ST_SUM) begin
			sum_q <= sum_full[SUM_W-1:0];
		end
	end

	// Mix and output
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W:0]         tot;
	logic signed [ACC_W:0]         tot_sh;
	logic signed [SAMPLE_BITS-1:0] o;
	logic signed [SAMPLE_BITS-1:0] left_res_q;
	logic [2*SAMPLE_BITS-1:0]      out_data_q;

	assign tot    = (ACC_W+1)'(acc_q) + (ACC_W+1)'($signed(prod[ACC_W-1:0])) + RND;
	assign tot_sh = tot >>> OUT_SHIFT;

	always_comb begin
		if (tot_sh > (ACC_W+1)'(O_MAX)) begin
			o = O_MAX;
		end else if (tot_sh < (ACC_W+1)'(O_MIN)) begin
			o = O_MIN;
		end else begin
			o = tot_sh[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.state == ST_MIXD) begin
			acc_q <= prod[ACC_W-1:0];
		end
		if (ctrl.state == ST_OUT && !ctrl.ch) begin
			left_res_q <= o;
		end
		if (ctrl.state == ST_OUT && ctrl.ch && out_free) begin
			out_data_q <= {o, left_res_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.state == ST_OUT && ctrl.ch && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// The block stays busy after taking a pair.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken again right after a transfer");

	// A store write goes back to the entry that was fetched for that stage.
	a_write_matches_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ($past(ctrl.ram_re, 7) && $past(ctrl.ram_raddr, 7) == wr_addr))
		else $error("slew store write does not match its read");

	a_stage_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.state == ST_WRITE) |-> (NST_W'(ctrl.stage) < nstages))
		else $error("stage index beyond the active stage count");

	// A result appears only from the right channel's output step.
	a_out_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(ctrl.state == ST_OUT) && $past(ctrl.ch)))
		else $error("result raised outside the output step");

endmodule

// File: tb/tb_sine_slew_cascade_saturator_core.sv
// ----------------------------------------------------------------------------
// tb_sine_slew_cascade_saturator_core
// Self-checking testbench for the stereo sine slew cascade saturator.
// ----------------------------------------------------------------------------
// Stereo pairs are fed through the slave stream port under a sequence of gain
// and stage count settings. A bit-exact behavioral copy of the cascade predicts
// each output pair when the input transfer happens. Output transfers are checked
// in order against those predictions. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_sine_slew_cascade_saturator_core import sssat_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RANDOM_PAIRS  = 550;
	localparam int          QUIET_TAIL    = 60;
	localparam int          CYCLE_LIMIT   = 1500000;
	localparam int          DRAIN_CYCLES  = 2000;
	localparam int          X0_SHIFT_TB   = 29 - SAMPLE_BITS;
	localparam logic [63:0] PHASE_STEP    = 64'd2734261102;
	localparam logic [63:0] QUARTER_TURN  = 64'd1686629713;

	typedef struct packed {
		logic [23:0] right;
		logic [23:0] left;
	} pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // left_sample [23:0], right_sample [47:24]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // left_out [23:0], right_out [47:24]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [17:0] cfg_data = '0;

	// Behavioral copy of the block: sine table, register file and slew memory.
	int                 sin_table [0:256];
	logic [16:0]        src_gain = 17'd65536;
	logic [7:0]         n_stages = 8'd1;
	logic signed [17:0] wet_weight = 18'sd65536;
	logic [16:0]        dry_weight = 17'd0;
	int                 slew_mem [2][MAX_STAGES];

	logic [47:0] pending_pairs [$];
	pair_t       awaited_pairs [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          send_gap = 0;
	int          sink_gap = 0;
	bit          quiet = 1'b0;

	sine_slew_cascade_saturator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Quarter wave of sin(k*pi/512) in Q1.30, alternating truncated Taylor terms.
	initial begin : sine_table_fill
		longint unsigned x;
		longint unsigned t;
		longint          acc;
		for (int k = 0; k <= 256; k++) begin
			x   = (64'(k) * QUARTER_TURN + 64'd128) / 64'd256;
			t   = x;
			acc = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				t = (((t * x) >> 30) * x) >> 30;
				t = t / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - longint'(t);
				end else begin
					acc = acc + longint'(t);
				end
			end
			sin_table[k] = int'(acc);
		end
	end

	function automatic longint table_sine(longint d);
		logic [63:0] prod;
		logic [31:0] phase;
		int          idx;
		longint      a;
		longint      b;
		longint      v;
		longint      f;
		prod  = d * PHASE_STEP;
		phase = prod[61:30];
		idx   = int'(phase[29:22]);
		f     = longint'(phase[21:0]);
		if (phase[30]) begin
			a = sin_table[256 - idx];
			b = sin_table[255 - idx];
		end else begin
			a = sin_table[idx];
			b = sin_table[idx + 1];
		end
		v = a + (((b - a) * f) >>> 22);
		return phase[31] ? -v : v;
	endfunction

	// Runs one channel through the active stages and the wet/dry mix.
	function automatic logic [23:0] shape_channel(int ch, logic [23:0] sample);
		int     stages;
		longint x0;
		longint x;
		longint s;
		longint half;
		longint y;
		longint acc;
		longint o;
		stages = (n_stages == 0) ? 1 : ((n_stages > MAX_STAGES) ? MAX_STAGES : int'(n_stages));
		x0 = longint'($signed(sample)) <<< X0_SHIFT_TB;
		x  = x0;
		for (int i = 0; i < stages; i++) begin
			s    = longint'(slew_mem[ch][i]);
			half = table_sine(s - x) >>> 3;
			y    = ((s + half) * longint'(src_gain)) >>> 16;
			if (y > 64'sd2147483647) begin
				y = 64'sd2147483647;
			end else if (y < -64'sd2147483648) begin
				y = -64'sd2147483648;
			end
			slew_mem[ch][i] = int'(y >>> 1);
			x = y;
		end
		if (stages % 2 == 1) begin
			x = -x;
		end
		acc = longint'(wet_weight) * x + longint'(dry_weight) * x0;
		o   = (acc + (64'sd1 <<< (44 - SAMPLE_BITS))) >>> (45 - SAMPLE_BITS);
		if (o > 64'sd8388607) begin
			o = 64'sd8388607;
		end else if (o < -64'sd8388608) begin
			o = -64'sd8388608;
		end
		return o[23:0];
	endfunction

	task automatic flag_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Source side: presents queued pairs, holds them until taken, idles in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap      <= 0;
		end else if (s_axis_tvalid && !s_axis_tready) begin
			s_axis_tvalid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap      <= send_gap - 1;
			s_axis_tvalid <= 1'b0;
		end else if (!quiet && $urandom_range(0, 2) == 0) begin
			send_gap      <= $urandom_range(0, 7);
			s_axis_tvalid <= 1'b0;
		end else if (pending_pairs.size() != 0) begin
			s_axis_tdata  <= pending_pairs.pop_front();
			s_axis_tvalid <= 1'b1;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Sink side: tracks register writes, predicts on input transfers and checks
	// output transfers, with its own bursts of backpressure.
	always @(posedge clk or negedge arst_n) begin : sink
		pair_t got;
		pair_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap      <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SOURCE_GAIN: src_gain   = cfg_data[16:0];
					CFG_STAGE_COUNT: n_stages   = cfg_data[7:0];
					CFG_WET_GAIN:    wet_weight = $signed(cfg_data);
					CFG_DRY_GAIN:    dry_weight = cfg_data[16:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (awaited_pairs.size() == 0) begin
					flag_mismatch($sformatf("output pair %h with nothing pending", got));
				end else begin
					want = awaited_pairs.pop_front();
					if (got.left !== want.left) begin
						flag_mismatch($sformatf("left_out %0d, predicted %0d",
							$signed(got.left), $signed(want.left)));
					end
					if (got.right !== want.right) begin
						flag_mismatch($sformatf("right_out %0d, predicted %0d",
							$signed(got.right), $signed(want.right)));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want.left  = shape_channel(0, s_axis_tdata[23:0]);
				want.right = shape_channel(1, s_axis_tdata[47:24]);
				awaited_pairs.push_back(want);
			end
			if (sink_gap > 0) begin
				sink_gap      <= sink_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				sink_gap      <= $urandom_range(0, 7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Returns at a falling edge once every queued pair is sent and answered.
	task automatic settle();
		do @(negedge clk);
		while (pending_pairs.size() != 0 || s_axis_tvalid || awaited_pairs.size() != 0);
	endtask

	task automatic write_register(cfg_reg_e_t idx, logic [17:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(logic [17:0] src, logic [17:0] cnt, logic [17:0] wet,
			logic [17:0] dry);
		settle();
		write_register(CFG_SOURCE_GAIN, src);
		write_register(CFG_STAGE_COUNT, cnt);
		write_register(CFG_WET_GAIN, wet);
		write_register(CFG_DRY_GAIN, dry);
		@(negedge clk);
	endtask

	function automatic logic [23:0] draw_sample();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0:       return 24'h7FFFFF;
					1:       return 24'h800000;
					2:       return 24'h000000;
					3:       return 24'hFFFFFF;
					default: return 24'h000001;
				endcase
			end
			1, 2:    return 24'($urandom_range(0, 8191)) - 24'd4096;
			default: return 24'($urandom());
		endcase
	endfunction

	initial begin
		int          sent_random;
		int          n_pairs;
		int          pick;
		logic [7:0]  cnt;
		logic [17:0] src;
		logic [17:0] wet;
		logic [17:0] dry;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: one stage, unity source and wet gain, no dry signal.
		pending_pairs.push_back({24'h000000, 24'h000000});
		pending_pairs.push_back({24'h800000, 24'h7FFFFF});
		pending_pairs.push_back({24'h7FFFFF, 24'h800000});
		pending_pairs.push_back({24'h000001, 24'hFFFFFF});
		pending_pairs.push_back({24'h7FFFFF, 24'h7FFFFF});
		pending_pairs.push_back({24'h800000, 24'h800000});

		// A stage count of zero behaves as a single stage.
		apply_setting(18'd65536, 18'h3FF00, -18'sd65536, 18'd65536);
		pending_pairs.push_back({24'h400000, 24'hC00000});
		pending_pairs.push_back({24'h000000, 24'h000000});
		pending_pairs.push_back({24'h7FFFFF, 24'h800000});

		// Counts above the store depth clamp to it; gains past their register width are truncated.
		apply_setting(18'h3FFFF, 18'h3FFFF, 18'h1FFFF, 18'h3FFFF);
		pending_pairs.push_back({24'h7FFFFF, 24'h7FFFFF});
		pending_pairs.push_back({24'h800000, 24'h800000});
		pending_pairs.push_back({24'h123456, 24'hEDCBA9});

		// Full depth with no source gain and the most negative wet weight.
		apply_setting(18'd0, 18'd128, 18'h20000, 18'd0);
		pending_pairs.push_back({24'h7FFFFF, 24'h800000});
		pending_pairs.push_back({24'h000000, 24'h000001});
		pending_pairs.push_back({24'hFFFFFF, 24'h7FFFFF});

		// Odd then even short cascades; deeper stores keep their old contents.
		apply_setting(18'd40000, 18'd3, 18'd65536, 18'd32768);
		pending_pairs.push_back({24'h200000, 24'hE00000});
		pending_pairs.push_back({24'h7FFFFF, 24'h000000});
		pending_pairs.push_back({24'h800000, 24'h7FFFFF});
		pending_pairs.push_back({24'h000000, 24'h000000});
		apply_setting(18'd65536, 18'd2, 18'h30000, 18'd65536);
		pending_pairs.push_back({24'h7FFFFF, 24'h800000});
		pending_pairs.push_back({24'h555555, 24'hAAAAAA});
		pending_pairs.push_back({24'h000000, 24'hFFFFFF});

		sent_random = 0;
		while (sent_random < RANDOM_PAIRS) begin
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				// Deep cascades are slow, so only a few pairs go through them.
				cnt     = 8'($urandom_range(128, 255));
				n_pairs = $urandom_range(2, 4);
			end else if (pick <= 3) begin
				cnt     = 8'($urandom_range(9, 24));
				n_pairs = $urandom_range(15, 30);
			end else begin
				cnt     = 8'($urandom_range(0, 8));
				n_pairs = $urandom_range(20, 40);
			end
			case ($urandom_range(0, 5))
				0:       src = 18'd65536;
				1:       src = 18'd0;
				2:       src = 18'($urandom());
				default: src = 18'($urandom_range(30000, 65536));
			endcase
			case ($urandom_range(0, 5))
				0:       wet = 18'd65536;
				1:       wet = -18'sd65536;
				2:       wet = 18'($urandom());
				default: wet = 18'($urandom_range(0, 131072)) - 18'd65536;
			endcase
			case ($urandom_range(0, 5))
				0:       dry = 18'd0;
				1:       dry = 18'd65536;
				2:       dry = 18'($urandom());
				default: dry = 18'($urandom_range(0, 65536));
			endcase
			apply_setting(src, {10'($urandom()), cnt}, wet, dry);
			quiet = (sent_random >= RANDOM_PAIRS - QUIET_TAIL) || ($urandom_range(0, 5) == 0);
			for (int i = 0; i < n_pairs; i++) begin
				pending_pairs.push_back({draw_sample(), draw_sample()});
			end
			sent_random += n_pairs;
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
